>>> rtl/core/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Types and codes shared by the cylinder supervisor modules.
// ----------------------------------------------------------------------------
package pcs_pkg;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_FWD   = 3'd1,
		OP_BWD   = 3'd2,
		OP_FREE  = 3'd3,
		OP_CLEAR = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_BWD  = 2'd2
	} dir_t;

	// drive codes for commands and the error action
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_FWD  = 2'd1;
	localparam logic [1:0] ACT_BWD  = 2'd2;
	localparam logic [1:0] ACT_FREE = 2'd3;

	// register indexes
	localparam logic [2:0] REG_SOLENOID_PRESENT = 3'd0;
	localparam logic [2:0] REG_SENSOR_PRESENT   = 3'd1;
	localparam logic [2:0] REG_TIME_LIMIT       = 3'd2;
	localparam logic [2:0] REG_ERROR_ENABLE     = 3'd3;
	localparam logic [2:0] REG_ERROR_ACTION     = 3'd4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int DELAY_W     = 16;

	typedef struct packed {
		logic [1:0]  solenoid_present;
		logic [1:0]  sensor_present;
		logic [15:0] time_limit;
		logic        error_enable;
		logic [1:0]  error_action;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic               sensor_a;
		logic               sensor_b;
		logic [DELAY_W-1:0] delay_fwd;
		logic [DELAY_W-1:0] delay_bwd;
	} item_t;

	typedef struct packed {
		logic [1:0] position;
		logic       drive_a;
		logic       drive_b;
		logic       moving;
		logic       fault;
	} result_t;

endpackage

>>> rtl/core/pcs_cfg.sv
// ----------------------------------------------------------------------------
// pcs_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module pcs_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [pcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [pcs_pkg::CFG_DATA_W-1:0]      cfg_data,
	output pcs_pkg::cfg_t                       cfg
);
	import pcs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.solenoid_present <= 2'd3;
			cfg_q.sensor_present   <= 2'd3;
			cfg_q.time_limit       <= 16'd5000;
			cfg_q.error_enable     <= 1'b0;
			cfg_q.error_action     <= ACT_NONE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SOLENOID_PRESENT: cfg_q.solenoid_present <= cfg_data[1:0];
				REG_SENSOR_PRESENT:   cfg_q.sensor_present   <= cfg_data[1:0];
				REG_TIME_LIMIT:       cfg_q.time_limit       <= cfg_data[15:0];
				REG_ERROR_ENABLE:     cfg_q.error_enable     <= cfg_data[0];
				REG_ERROR_ACTION:     cfg_q.error_action     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/pcs_core.sv
// ----------------------------------------------------------------------------
// pcs_core
// Cylinder state, timers and the per-item update; yields the result of an item.
// ----------------------------------------------------------------------------
module pcs_core #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  pcs_pkg::item_t   item,
	input  pcs_pkg::cfg_t    cfg,
	output pcs_pkg::result_t result
);
	import pcs_pkg::*;

	localparam int CMP_W = (TIMER_WIDTH > DELAY_W) ? TIMER_WIDTH : DELAY_W;

	logic                   drive_a_q, drive_b_q;
	logic [DELAY_W-1:0]     delay_fwd_q, delay_bwd_q, active_delay_q;
	dir_t                   out_dir_q, in_dir_q;
	logic [TIMER_WIDTH-1:0] settle_timer_q, fault_timer_q;
	logic                   moving_q, fault_q;

	logic                   drive_a_d, drive_b_d;
	logic [DELAY_W-1:0]     delay_fwd_d, delay_bwd_d, active_delay_d;
	dir_t                   out_dir_d, in_dir_d;
	logic [TIMER_WIDTH-1:0] settle_timer_d, fault_timer_d;
	logic                   moving_d, fault_d;
	logic                   oa, ob, ia, ib;
	logic                   settled;

	function automatic logic [1:0] apply_dir(input logic [1:0] act, input logic [1:0] sol,
			input logic a, input logic b);
		logic na, nb;
		na = a;
		nb = b;
		case (act)
			ACT_FWD:  begin na = 1'b1; nb = 1'b0; end
			ACT_BWD:  begin na = 1'b0; nb = 1'b1; end
			ACT_FREE: begin na = 1'b0; nb = 1'b0; end
			default: ;
		endcase
		return {sol[1] ? nb : b, sol[0] ? na : a};
	endfunction

	always_comb begin
		drive_a_d      = drive_a_q;
		drive_b_d      = drive_b_q;
		delay_fwd_d    = delay_fwd_q;
		delay_bwd_d    = delay_bwd_q;
		active_delay_d = active_delay_q;
		out_dir_d      = out_dir_q;
		in_dir_d       = in_dir_q;
		settle_timer_d = settle_timer_q;
		fault_timer_d  = fault_timer_q;
		moving_d       = moving_q;
		fault_d        = fault_q;
		oa = 1'b0;
		ob = 1'b0;
		ia = 1'b0;
		ib = 1'b0;

		case (item.opcode)
			OP_TICK: begin
				if (settle_timer_q != '1) settle_timer_d = settle_timer_q + 1'b1;
				if (fault_timer_q != '1)  fault_timer_d  = fault_timer_q + 1'b1;

				case (cfg.solenoid_present)
					2'd1:    begin oa = drive_a_q; ob = !drive_a_q; end
					2'd2:    begin ob = drive_b_q; oa = !drive_b_q; end
					2'd3:    begin oa = drive_a_q; ob = drive_b_q; end
					default: begin oa = 1'b0; ob = 1'b0; end
				endcase

				case (cfg.sensor_present)
					2'd1:    begin ia = item.sensor_a; ib = !item.sensor_a; end
					2'd2:    begin ib = item.sensor_b; ia = !item.sensor_b; end
					2'd3:    begin ia = item.sensor_a; ib = item.sensor_b; end
					default: begin ia = oa; ib = ob; end
				endcase

				if (ia && !ib)      in_dir_d = DIR_FWD;
				else if (!ia && ib) in_dir_d = DIR_BWD;
				else                in_dir_d = DIR_NONE;

				if ((oa && !ob) || (oa == ob && ia && !ib))      out_dir_d = DIR_FWD;
				else if ((!oa && ob) || (oa == ob && !ia && ib)) out_dir_d = DIR_BWD;
				else                                             out_dir_d = DIR_NONE;

				if (out_dir_d != out_dir_q) begin
					if (out_dir_d != DIR_NONE) moving_d = 1'b1;
					active_delay_d = (out_dir_d == DIR_FWD) ? delay_fwd_q : delay_bwd_q;
					settle_timer_d = '0;
					fault_timer_d  = '0;
				end

				if (in_dir_d == out_dir_d && out_dir_d != DIR_NONE &&
						CMP_W'(settle_timer_d) >= CMP_W'(active_delay_d)) begin
					moving_d      = 1'b0;
					fault_timer_d = '0;
				end

				if (cfg.error_enable && cfg.sensor_present != 2'd0 &&
						CMP_W'(fault_timer_d) >= CMP_W'(cfg.time_limit)) begin
					moving_d = 1'b0;
					if (!fault_q)
						{drive_b_d, drive_a_d} = apply_dir(cfg.error_action,
							cfg.solenoid_present, drive_a_q, drive_b_q);
					fault_d = 1'b1;
				end
			end
			OP_FWD, OP_BWD: begin
				delay_fwd_d = item.delay_fwd;
				delay_bwd_d = item.delay_bwd;
				{drive_b_d, drive_a_d} = apply_dir(item.opcode[1:0], cfg.solenoid_present,
					drive_a_q, drive_b_q);
			end
			OP_FREE: begin
				{drive_b_d, drive_a_d} = apply_dir(ACT_FREE, cfg.solenoid_present,
					drive_a_q, drive_b_q);
			end
			OP_CLEAR: begin
				fault_d       = 1'b0;
				fault_timer_d = '0;
			end
			default: ;
		endcase

		settled = in_dir_d == out_dir_d && out_dir_d != DIR_NONE &&
			CMP_W'(settle_timer_d) >= CMP_W'(active_delay_d);

		result.position = settled ? out_dir_d : DIR_NONE;
		result.drive_a  = cfg.solenoid_present[0] & drive_a_d;
		result.drive_b  = cfg.solenoid_present[1] & drive_b_d;
		result.moving   = moving_d;
		result.fault    = fault_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_a_q      <= 1'b0;
			drive_b_q      <= 1'b0;
			delay_fwd_q    <= '0;
			delay_bwd_q    <= '0;
			active_delay_q <= '0;
			out_dir_q      <= DIR_NONE;
			in_dir_q       <= DIR_NONE;
			settle_timer_q <= '0;
			fault_timer_q  <= '0;
			moving_q       <= 1'b0;
			fault_q        <= 1'b0;
		end else if (step) begin
			drive_a_q      <= drive_a_d;
			drive_b_q      <= drive_b_d;
			delay_fwd_q    <= delay_fwd_d;
			delay_bwd_q    <= delay_bwd_d;
			active_delay_q <= active_delay_d;
			out_dir_q      <= out_dir_d;
			in_dir_q       <= in_dir_d;
			settle_timer_q <= settle_timer_d;
			fault_timer_q  <= fault_timer_d;
			moving_q       <= moving_d;
			fault_q        <= fault_d;
		end
	end

endmodule

>>> rtl/core/pneumatic_cylinder_supervisor.sv
// ----------------------------------------------------------------------------
// pneumatic_cylinder_supervisor
// Supervisor for one double-acting cylinder: drives, settle and timeout logic.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          contents
//  s_*       in         s_tvalid/s_tready  tick, drive and clear-error items
//  m_*       out        m_tvalid/m_tready  one result item per input item
//  cfg_*     in         cfg_wr_en          register writes, no read-back
//
//  an item is registered on acceptance and then updated into the result register
//  when the result side can take it, so one item per clock is sustained while m_tready is high
//  the combinational state update in pcs_core sets the rate
//  reset clears the handshake state, the cylinder state and the configuration registers
//  a stalled result holds the update stage; one item waits in the input register
// ----------------------------------------------------------------------------
module pneumatic_cylinder_supervisor #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [39:0]                     s_tdata,  // sensor_a, sensor_b, delay_fwd, delay_bwd
	input  logic [2:0]                      s_tuser,  // opcode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,  // position, drive_a, drive_b, moving, fault
	input  logic                            cfg_wr_en,
	input  logic [pcs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pcs_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t result_q;
	logic    valid_q;
	logic    step;

	assign step     = valid_s1 && (!valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.opcode    <= s_tuser;
			item_s1.sensor_a  <= s_tdata[0];
			item_s1.sensor_b  <= s_tdata[1];
			item_s1.delay_fwd <= s_tdata[17:2];
			item_s1.delay_bwd <= s_tdata[33:18];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
		end
	end

	pcs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pcs_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, result_q.fault, result_q.moving, result_q.drive_b,
		result_q.drive_a, result_q.position};

endmodule

>>> dv/pcs_checker.sv
// ----------------------------------------------------------------------------
// pcs_checker
// Watches the item, result and register write channels of the cylinder
// supervisor, keeps its own copy of the cylinder state and register values,
// works out the result of every accepted item and compares each returned
// result with the oldest outstanding one.
// ----------------------------------------------------------------------------
module pcs_checker #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [39:0]                     s_tdata,  // sensor_a, sensor_b, delay_fwd, delay_bwd
	input  logic [2:0]                      s_tuser,  // opcode
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [7:0]                      m_tdata,  // position, drive_a, drive_b, moving, fault
	input  logic                            cfg_wr_en,
	input  logic [pcs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pcs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              mismatches,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pcs_pkg::*;

	cfg_t                   regs;
	logic                   drv_a;
	logic                   drv_b;
	logic [DELAY_W-1:0]     dly_fwd;
	logic [DELAY_W-1:0]     dly_bwd;
	logic [DELAY_W-1:0]     act_dly;
	dir_t                   cmd_dir;
	dir_t                   sns_dir;
	logic [TIMER_WIDTH-1:0] settle_cnt;
	logic [TIMER_WIDTH-1:0] fault_cnt;
	logic                   moving_q;
	logic                   fault_q;
	result_t                cylinder_results[$];

	function automatic logic at_rest();
		return sns_dir == cmd_dir && cmd_dir != DIR_NONE && settle_cnt >= act_dly;
	endfunction

	function automatic void set_drives(input logic a, input logic b);
		if (regs.solenoid_present[0])
			drv_a = a;
		if (regs.solenoid_present[1])
			drv_b = b;
	endfunction

	function automatic void apply_drive(input logic [1:0] act);
		case (act)
			ACT_FWD:  set_drives(1'b1, 1'b0);
			ACT_BWD:  set_drives(1'b0, 1'b1);
			ACT_FREE: set_drives(1'b0, 1'b0);
			default: ;
		endcase
	endfunction

	function automatic void run_tick(input logic sa, input logic sb);
		logic oa;
		logic ob;
		logic ia;
		logic ib;
		dir_t nxt;
		if (settle_cnt != '1)
			settle_cnt = settle_cnt + 1'b1;
		if (fault_cnt != '1)
			fault_cnt = fault_cnt + 1'b1;

		// a missing solenoid or sensor mirrors the other one
		case (regs.solenoid_present)
			2'b01: begin oa = drv_a; ob = !oa; end
			2'b10: begin ob = drv_b; oa = !ob; end
			2'b11: begin oa = drv_a; ob = drv_b; end
			default: begin oa = 1'b0; ob = 1'b0; end
		endcase
		case (regs.sensor_present)
			2'b01: begin ia = sa; ib = !ia; end
			2'b10: begin ib = sb; ia = !ib; end
			2'b11: begin ia = sa; ib = sb; end
			default: begin ia = oa; ib = ob; end
		endcase

		if (ia && !ib)
			sns_dir = DIR_FWD;
		else if (!ia && ib)
			sns_dir = DIR_BWD;
		else
			sns_dir = DIR_NONE;

		if ((oa && !ob) || (oa == ob && ia && !ib))
			nxt = DIR_FWD;
		else if ((!oa && ob) || (oa == ob && !ia && ib))
			nxt = DIR_BWD;
		else
			nxt = DIR_NONE;

		if (nxt != cmd_dir) begin
			if (nxt != DIR_NONE)
				moving_q = 1'b1;
			act_dly = (nxt == DIR_FWD) ? dly_fwd : dly_bwd;
			settle_cnt = '0;
			fault_cnt = '0;
		end
		cmd_dir = nxt;

		if (at_rest()) begin
			moving_q = 1'b0;
			fault_cnt = '0;
		end

		if (regs.error_enable && regs.sensor_present != 2'b00 &&
				fault_cnt >= regs.time_limit) begin
			moving_q = 1'b0;
			if (!fault_q)
				apply_drive(regs.error_action);
			fault_q = 1'b1;
		end
	endfunction

	function automatic result_t cylinder_step(input logic [2:0] op, input logic [39:0] d);
		result_t r;
		case (op)
			OP_TICK: run_tick(d[0], d[1]);
			OP_FWD, OP_BWD: begin
				dly_fwd = d[17:2];
				dly_bwd = d[33:18];
				apply_drive(op == OP_FWD ? ACT_FWD : ACT_BWD);
			end
			OP_FREE: apply_drive(ACT_FREE);
			OP_CLEAR: begin
				fault_q = 1'b0;
				fault_cnt = '0;
			end
			default: ;
		endcase
		r.position = at_rest() ? cmd_dir : DIR_NONE;
		r.drive_a  = regs.solenoid_present[0] & drv_a;
		r.drive_b  = regs.solenoid_present[1] & drv_b;
		r.moving   = moving_q;
		r.fault    = fault_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			regs = '{2'b11, 2'b11, 16'd5000, 1'b0, ACT_NONE};
			drv_a = 1'b0;
			drv_b = 1'b0;
			dly_fwd = '0;
			dly_bwd = '0;
			act_dly = '0;
			cmd_dir = DIR_NONE;
			sns_dir = DIR_NONE;
			settle_cnt = '0;
			fault_cnt = '0;
			moving_q = 1'b0;
			fault_q = 1'b0;
			cylinder_results.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.position = m_tdata[1:0];
				got.drive_a  = m_tdata[2];
				got.drive_b  = m_tdata[3];
				got.moving   = m_tdata[4];
				got.fault    = m_tdata[5];
				if (cylinder_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result pos=%0d a=%0b b=%0b mov=%0b flt=%0b",
							$time, got.position, got.drive_a, got.drive_b, got.moving,
							got.fault);
				end else begin
					want = cylinder_results.pop_front();
					if (got.position !== want.position || got.drive_a !== want.drive_a ||
							got.drive_b !== want.drive_b || got.moving !== want.moving ||
							got.fault !== want.fault) begin
						mismatches++;
						if (mismatches <= 10)
							$display(
								"%0t: expected p=%0d a=%0b b=%0b m=%0b f=%0b, got p=%0d a=%0b b=%0b m=%0b f=%0b",
								$time, want.position, want.drive_a, want.drive_b,
								want.moving, want.fault, got.position, got.drive_a,
								got.drive_b, got.moving, got.fault);
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SOLENOID_PRESENT: regs.solenoid_present = cfg_data[1:0];
					REG_SENSOR_PRESENT:   regs.sensor_present = cfg_data[1:0];
					REG_TIME_LIMIT:       regs.time_limit = cfg_data[15:0];
					REG_ERROR_ENABLE:     regs.error_enable = cfg_data[0];
					REG_ERROR_ACTION:     regs.error_action = cfg_data[1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				cylinder_results.push_back(cylinder_step(s_tuser, s_tdata));
			pending = cylinder_results.size();
		end
	end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the cylinder supervisor: a directed run through the commands,
// sensor patterns and spare opcodes, then phases of random move sequences
// under different register settings with random gaps on one or both channels.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pcs_pkg::*;

	localparam int TIMER_W = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 230;
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [39:0]            s_tdata;
	logic [2:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [7:0]             m_tdata;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     mismatches;
	int                     pending;
	int                     cycles;
	bit                     send_gaps;
	bit                     recv_stalls;
	cfg_t                   phase_cfg[PHASES];

	pneumatic_cylinder_supervisor #(
		.TIMER_WIDTH(TIMER_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	pcs_checker #(
		.TIMER_WIDTH(TIMER_W)
	) u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: bursts of back-pressure, mostly short
	initial begin
		int n;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (!recv_stalls) begin
				m_tready <= 1'b1;
			end else begin
				n = $urandom_range(0, 99);
				n = (n < 70) ? $urandom_range(1, 3) :
					(n < 90) ? $urandom_range(4, 8) : $urandom_range(15, 50);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
				m_tready <= 1'b1;
				repeat ($urandom_range(0, 6)) @(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (!send_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_item(input logic [2:0] op, input logic sa, input logic sb,
			input logic [15:0] df, input logic [15:0] db);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'b0, db, df, sb, sa};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_tick(input logic sa, input logic sb);
		send_item(OP_TICK, sa, sb, 16'($urandom), 16'($urandom));
	endtask

	// sender holds off until every outstanding result is back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input cfg_t c, input bit stray);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_SOLENOID_PRESENT;
		cfg_data  <= 16'(c.solenoid_present);
		@(posedge clk);
		cfg_index <= REG_SENSOR_PRESENT;
		cfg_data  <= 16'(c.sensor_present);
		@(posedge clk);
		cfg_index <= REG_TIME_LIMIT;
		cfg_data  <= c.time_limit;
		@(posedge clk);
		cfg_index <= REG_ERROR_ENABLE;
		cfg_data  <= 16'(c.error_enable);
		@(posedge clk);
		cfg_index <= REG_ERROR_ACTION;
		cfg_data  <= 16'(c.error_action);
		@(posedge clk);
		if (stray) begin
			cfg_index <= REG_UNUSED;
			cfg_data  <= 16'($urandom);
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [15:0] pick_delay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 16'($urandom_range(0, 8));
		if (r < 92)
			return 16'($urandom_range(0, 40));
		return 16'($urandom);
	endfunction

	// mostly well-formed moves: command, travel with both sensors off,
	// then the target sensor held; the rest is sensor noise and odd items
	task automatic random_moves(input int count);
		int sent;
		int r;
		int k;
		logic [2:0] op;
		logic fwd;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 72) begin
				k = $urandom_range(0, 9);
				op = (k < 4) ? OP_FWD : (k < 8) ? OP_BWD : OP_FREE;
				send_item(op, 1'($urandom), 1'($urandom), pick_delay(), pick_delay());
				sent++;
				fwd = (op == OP_FWD) ? 1'b1 : (op == OP_BWD) ? 1'b0 : 1'($urandom);
				repeat ($urandom_range(0, 10)) begin
					if ($urandom_range(0, 9) == 0)
						send_tick(1'($urandom), 1'($urandom));
					else
						send_tick(1'b0, 1'b0);
					sent++;
				end
				repeat ($urandom_range(1, 14)) begin
					send_tick(fwd, !fwd);
					sent++;
				end
				if ($urandom_range(0, 7) == 0) begin
					send_item(OP_CLEAR, 1'($urandom), 1'($urandom), 16'($urandom),
						16'($urandom));
					sent++;
				end
			end else if (r < 90) begin
				repeat ($urandom_range(1, 6)) begin
					send_tick(1'($urandom), 1'($urandom));
					sent++;
				end
			end else begin
				send_item(3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom),
					16'($urandom), 16'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = OP_TICK;
		cfg_wr_en   = 1'b0;
		cfg_index   = REG_SOLENOID_PRESENT;
		cfg_data    = '0;
		cycles      = 0;
		send_gaps   = 1'b0;
		recv_stalls = 1'b0;

		phase_cfg[0] = '{2'b11, 2'b11, 16'd30, 1'b1, ACT_FREE};
		phase_cfg[1] = '{2'b01, 2'b10, 16'd0, 1'b1, ACT_FWD};
		phase_cfg[2] = '{2'b10, 2'b01, 16'hFFFF, 1'b1, ACT_BWD};
		phase_cfg[3] = '{2'b00, 2'b11, 16'd10, 1'b1, ACT_NONE};
		phase_cfg[4] = '{2'b11, 2'b00, 16'd0, 1'b1, ACT_FREE};
		phase_cfg[5] = '{2'b11, 2'b11, 16'd5000, 1'b0, ACT_BWD};
		for (int p = 6; p < PHASES; p++) begin
			phase_cfg[p].solenoid_present = 2'($urandom);
			phase_cfg[p].sensor_present   = 2'($urandom);
			phase_cfg[p].time_limit       = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
				16'($urandom_range(0, 40));
			phase_cfg[p].error_enable     = 1'($urandom);
			phase_cfg[p].error_action     = 2'($urandom);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass under the reset settings
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_item(OP_FWD, 1'b0, 1'b0, 16'h0000, 16'hFFFF);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_item(OP_BWD, 1'b1, 1'b1, 16'hFFFF, 16'h0000);
		send_tick(1'b0, 1'b1);
		send_item(OP_FWD, 1'b0, 1'b0, 16'd3, 16'd5);
		repeat (4) send_tick(1'b1, 1'b0);
		send_item(OP_FREE, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_item(OP_CLEAR, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
		send_item(OP_SPARE_5, 1'b1, 1'b0, 16'h1234, 16'hFFFF);
		send_item(OP_SPARE_6, 1'b0, 1'b1, 16'hFFFF, 16'h0000);
		send_item(OP_SPARE_7, 1'b1, 1'b1, 16'h0000, 16'hABCD);
		send_tick(1'b1, 1'b1);
		send_item(OP_BWD, 1'b0, 1'b0, 16'hAAAA, 16'h5555);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			write_regs(phase_cfg[p], p == 1);
			send_gaps   = (p % 3) != 0;
			recv_stalls = (p % 3) != 1;
			@(posedge clk);
			random_moves(PHASE_ITEMS / 2);
			if (p == 2)
				wait_idle();
			random_moves(PHASE_ITEMS - PHASE_ITEMS / 2);
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/pcs_pkg.sv
rtl/core/pcs_cfg.sv
rtl/core/pcs_core.sv
rtl/core/pneumatic_cylinder_supervisor.sv
dv/pcs_checker.sv
dv/tb.sv
